/* rtl/ltwp_pkg.sv */
// Package for the least-loaded worker picker: transfer structs, command and
// status codes, and the microcode program of the sequencer.
// No dependencies; every other file imports it.
`timescale 1ns / 1ps

package ltwp_pkg;

  localparam int MAX_WORKERS_DEF = 16;
  localparam int LOAD_BITS_DEF   = 24;
  localparam int TOTAL_W         = 28;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_REL  = 2'd1,
    CMD_PICK = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_FULL       = 3'd1,
    ST_BAD_INDEX  = 3'd2,
    ST_ZERO_LOAD  = 3'd3,
    ST_NO_WORKERS = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] worker_tag;
    logic [3:0]  worker_index;
  } req_t;

  typedef struct packed {
    logic [3:0]  slot_index;
    logic [31:0] chosen_tag;
    logic [2:0]  status;
  } rsp_t;

  // Datapath operations of one microcode step.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_ADD,
    OP_RD_IDX,
    OP_REL,
    OP_SCAN_INIT,
    OP_RD_SLOT,
    OP_MUL,
    OP_SCAN_NEXT,
    OP_PICK,
    OP_RES_BAD,
    OP_RES_FULL,
    OP_RES_ZERO,
    OP_RES_NOWK
  } op_e;

  // Jump conditions; when the condition is false the step counter advances.
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_START,
    C_CMD_ADD,
    C_CMD_REL,
    C_CMD_PICK,
    C_FULL,
    C_BAD_IDX,
    C_LOAD_ZERO,
    C_EMPTY,
    C_QUAL,
    C_LAST
  } cond_e;

  localparam int UPC_W = 5;
  typedef logic [UPC_W-1:0] upc_t;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    upc_t  target;
  } ucode_t;

  localparam upc_t U_IDLE     = 5'd0;
  localparam upc_t U_ERR_BAD  = 5'd4;
  localparam upc_t U_ADD      = 5'd5;
  localparam upc_t U_ERR_FULL = 5'd7;
  localparam upc_t U_REL      = 5'd8;
  localparam upc_t U_ERR_ZERO = 5'd12;
  localparam upc_t U_PICK     = 5'd13;
  localparam upc_t U_SCAN     = 5'd15;
  localparam upc_t U_HIT      = 5'd20;
  localparam upc_t U_ERR_NOWK = 5'd21;

  function automatic ucode_t ucode_rom(input upc_t addr);
    ucode_t w;
    unique case (addr)
      5'd0:    w = '{OP_NOP,       C_NO_START,  U_IDLE};
      5'd1:    w = '{OP_NOP,       C_CMD_ADD,   U_ADD};
      5'd2:    w = '{OP_NOP,       C_CMD_REL,   U_REL};
      5'd3:    w = '{OP_NOP,       C_CMD_PICK,  U_PICK};
      5'd4:    w = '{OP_RES_BAD,   C_ALWAYS,    U_IDLE};
      5'd5:    w = '{OP_NOP,       C_FULL,      U_ERR_FULL};
      5'd6:    w = '{OP_ADD,       C_ALWAYS,    U_IDLE};
      5'd7:    w = '{OP_RES_FULL,  C_ALWAYS,    U_IDLE};
      5'd8:    w = '{OP_NOP,       C_BAD_IDX,   U_ERR_BAD};
      5'd9:    w = '{OP_RD_IDX,    C_NEVER,     U_IDLE};
      5'd10:   w = '{OP_NOP,       C_LOAD_ZERO, U_ERR_ZERO};
      5'd11:   w = '{OP_REL,       C_ALWAYS,    U_IDLE};
      5'd12:   w = '{OP_RES_ZERO,  C_ALWAYS,    U_IDLE};
      5'd13:   w = '{OP_NOP,       C_EMPTY,     U_ERR_NOWK};
      5'd14:   w = '{OP_SCAN_INIT, C_NEVER,     U_IDLE};
      5'd15:   w = '{OP_RD_SLOT,   C_NEVER,     U_IDLE};
      5'd16:   w = '{OP_MUL,       C_NEVER,     U_IDLE};
      5'd17:   w = '{OP_NOP,       C_QUAL,      U_HIT};
      5'd18:   w = '{OP_SCAN_NEXT, C_LAST,      U_ERR_NOWK};
      5'd19:   w = '{OP_NOP,       C_ALWAYS,    U_SCAN};
      5'd20:   w = '{OP_PICK,      C_ALWAYS,    U_IDLE};
      5'd21:   w = '{OP_RES_NOWK,  C_ALWAYS,    U_IDLE};
      default: w = '{OP_NOP,       C_ALWAYS,    U_IDLE};
    endcase
    return w;
  endfunction

endpackage

/* rtl/load_threshold_worker_picker_unit.sv */
// Top level of the least-loaded round-robin worker picker: a microcoded
// sequencer over a load memory, a tag memory and one multiplier.
// Depends on ltwp_pkg for types, codes and the microcode program.
//
//   Channel   Ports             Transfer when
//   command   start, req_i      rising edge with start high and busy low
//   result    done_o, rsp_o     rising edge ending the single cycle done_o is high
//
// Pick scans the slots in turn, at most the worker count of them; each slot
// costs a memory read, a registered multiply and a compare, stepped by the
// microcode. An empty table ends the pick with an error result.
// Reset clears the worker count, total load and pointer; no clearing pass is
// needed because add zeroes a slot's load when it fills the slot.
// The receiver cannot stall; busy stays high until the result strobe.
`timescale 1ns / 1ps

module load_threshold_worker_picker_unit
  import ltwp_pkg::*;
#(
  parameter int MAX_WORKERS = MAX_WORKERS_DEF,
  parameter int LOAD_BITS   = LOAD_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);

  localparam int IDX_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int CNT_W = $clog2(MAX_WORKERS + 1);
  localparam int IXC_W = (CNT_W > 4) ? CNT_W : 4;
  localparam int PR_W  = LOAD_BITS + CNT_W;
  localparam int CMP_W = (PR_W + 4 > TOTAL_W + 5) ? PR_W + 4 : TOTAL_W + 5;
  localparam logic [LOAD_BITS-1:0] LOAD_MAX = {LOAD_BITS{1'b1}};

  // Sequencer and control state.
  upc_t               upc_q, upc_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic [IDX_W-1:0]   ptr_q, ptr_d;
  logic               done_q, done_d;

  // Datapath registers.
  req_t               req_q;
  logic [IDX_W-1:0]   slot_q, k_q;
  logic [PR_W-1:0]    prod_q;
  logic [LOAD_BITS-1:0] load_rd_q;
  logic [31:0]        tag_rd_q;
  rsp_t               rsp_q, rsp_d;

  // Memories.
  logic [LOAD_BITS-1:0] load_mem [MAX_WORKERS];
  logic [31:0]          tag_mem  [MAX_WORKERS];

  ucode_t               uw;
  logic                 take;
  logic                 accept;
  logic                 load_we, load_re, tag_we;
  logic [IDX_W-1:0]     load_wa, load_ra, idx_addr, cnt_addr, slot_next, ptr_next;
  logic [LOAD_BITS-1:0] load_wd;
  logic [CMP_W-1:0]     lhs, rhs;
  logic                 qual, full, bad_idx, last;

  assign uw       = ucode_rom(upc_q);
  assign busy     = (upc_q != U_IDLE);
  assign accept   = start && !busy;
  assign idx_addr = IDX_W'(req_q.worker_index);
  assign cnt_addr = IDX_W'(count_q);

  assign full    = (count_q >= CNT_W'(MAX_WORKERS));
  assign bad_idx = (IXC_W'(req_q.worker_index) >= IXC_W'(count_q));
  assign last    = ((CNT_W'(k_q) + CNT_W'(1)) == count_q);

  // Wrap-around successors; both operands stay below the worker count.
  assign slot_next = ((CNT_W'(slot_q) + CNT_W'(1)) == count_q) ? '0 : slot_q + IDX_W'(1);
  assign ptr_next  = ((CNT_W'(ptr_q) + CNT_W'(1)) == count_q) ? '0 : ptr_q + IDX_W'(1);

  // load*2^32 < floor(total*(2^32+2^28)/count)+1 is the same as
  // load*count*16 <= total*17, so no divider is needed.
  assign lhs  = CMP_W'({prod_q, 4'b0000});
  assign rhs  = (CMP_W'(total_q) << 4) + CMP_W'(total_q);
  assign qual = (lhs <= rhs);

  always_comb begin
    unique case (uw.cond)
      C_NEVER:     take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_NO_START:  take = !start;
      C_CMD_ADD:   take = (req_q.command == CMD_ADD);
      C_CMD_REL:   take = (req_q.command == CMD_REL);
      C_CMD_PICK:  take = (req_q.command == CMD_PICK);
      C_FULL:      take = full;
      C_BAD_IDX:   take = bad_idx;
      C_LOAD_ZERO: take = (load_rd_q == '0);
      C_EMPTY:     take = (count_q == '0);
      C_QUAL:      take = qual;
      C_LAST:      take = last;
      default:     take = 1'b0;
    endcase
    upc_d = take ? uw.target : upc_q + upc_t'(1);
  end

  always_comb begin
    count_d = count_q;
    total_d = total_q;
    ptr_d   = ptr_q;
    done_d  = 1'b0;
    rsp_d   = '0;
    load_we = 1'b0;
    load_wa = cnt_addr;
    load_wd = '0;
    load_re = 1'b0;
    load_ra = idx_addr;
    tag_we  = 1'b0;
    unique case (uw.op)
      OP_ADD: begin
        tag_we           = 1'b1;
        load_we          = 1'b1;
        count_d          = count_q + CNT_W'(1);
        done_d           = 1'b1;
        rsp_d.slot_index = 4'(count_q);
        rsp_d.status     = ST_OK;
      end
      OP_RD_IDX: begin
        load_re = 1'b1;
      end
      OP_REL: begin
        load_we          = 1'b1;
        load_wa          = idx_addr;
        load_wd          = load_rd_q - LOAD_BITS'(1);
        if (total_q != '0) begin
          total_d = total_q - TOTAL_W'(1);
        end
        done_d           = 1'b1;
        rsp_d.slot_index = req_q.worker_index;
        rsp_d.status     = ST_OK;
      end
      OP_RD_SLOT: begin
        load_re = 1'b1;
        load_ra = slot_q;
      end
      OP_PICK: begin
        if (load_rd_q != LOAD_MAX) begin
          load_we = 1'b1;
          load_wa = slot_q;
          load_wd = load_rd_q + LOAD_BITS'(1);
          if (total_q != TOTAL_MAX) begin
            total_d = total_q + TOTAL_W'(1);
          end
        end
        ptr_d            = slot_q;
        done_d           = 1'b1;
        rsp_d.slot_index = 4'(slot_q);
        rsp_d.chosen_tag = tag_rd_q;
        rsp_d.status     = ST_OK;
      end
      OP_RES_BAD: begin
        done_d       = 1'b1;
        rsp_d.status = ST_BAD_INDEX;
      end
      OP_RES_FULL: begin
        done_d       = 1'b1;
        rsp_d.status = ST_FULL;
      end
      OP_RES_ZERO: begin
        done_d       = 1'b1;
        rsp_d.status = ST_ZERO_LOAD;
      end
      OP_RES_NOWK: begin
        done_d       = 1'b1;
        rsp_d.status = ST_NO_WORKERS;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q   <= U_IDLE;
      count_q <= '0;
      total_q <= '0;
      ptr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      upc_q   <= upc_d;
      count_q <= count_d;
      total_q <= total_d;
      ptr_q   <= ptr_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    if (uw.op == OP_SCAN_INIT) begin
      slot_q <= ptr_next;
      k_q    <= '0;
    end else if (uw.op == OP_SCAN_NEXT) begin
      slot_q <= slot_next;
      k_q    <= k_q + IDX_W'(1);
    end
    if (uw.op == OP_MUL) begin
      prod_q <= PR_W'(load_rd_q) * PR_W'(count_q);
    end
    if (done_d) begin
      rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_we) begin
      load_mem[load_wa] <= load_wd;
    end
    if (load_re) begin
      load_rd_q <= load_mem[load_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tag_we) begin
      tag_mem[cnt_addr] <= req_q.worker_tag;
    end
    if (load_re) begin
      tag_rd_q <= tag_mem[load_ra];
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

/* rtl/ltwp_checker.sv */
// Port-level checker for the worker picker and its bind to the top level.
// Depends on ltwp_pkg and on load_threshold_worker_picker_unit.
`timescale 1ns / 1ps

module ltwp_checker
  import ltwp_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input rsp_t rsp_o
);

  // An accepted command always makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted command did not raise busy");

  // The block only goes idle by delivering a result.
  a_idle_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy dropped without a result transfer");

  // A result is never shown while a command is still being worked on.
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // Error results carry no slot and no tag.
  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (rsp_o.status != ST_OK) |->
      (rsp_o.slot_index == 4'd0) && (rsp_o.chosen_tag == 32'd0))
    else $error("error result with nonzero slot or tag");

  // Strobes never run back to back; each command yields exactly one.
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe lasted more than one cycle");

endmodule

bind load_threshold_worker_picker_unit ltwp_checker u_ltwp_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);
